/* design/hsl_to_rgb_converter_unit_assert.svh */
// assertion macros for the hsl to rgb converter checker
`ifndef HSL_TO_RGB_CONVERTER_UNIT_ASSERT_SVH
`define HSL_TO_RGB_CONVERTER_UNIT_ASSERT_SVH

// same-cycle implication, checked in and out of reset
`define H2R_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked in and out of reset
`define H2R_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) else $error(msg);

// next-cycle implication, ignored while reset is high
`define H2R_ASSERT_NEXT_RUN(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) \
      (ante) |=> (cons)) else $error(msg);

`endif

/* design/hsl2rgb_pkg.sv */
// shared types and constants of the hsl to rgb converter
`default_nettype none
package hsl2rgb_pkg;

   // input and output field widths
   localparam int HUE_W  = 9;
   localparam int FRAC_W = 8;
   localparam int CN_W   = 16;
   localparam int TRI_W  = 6;
   localparam int HM_W   = 7;

   // numerators over 120*255 per output step, max 255*30600
   localparam int NUM_W  = 23;

   // hue bounds of the six sectors
   localparam logic [HUE_W-1:0] HUE_WRAP = 9'd360;
   localparam logic [HUE_W-1:0] HUE_60   = 9'd60;
   localparam logic [HUE_W-1:0] HUE_120  = 9'd120;
   localparam logic [HUE_W-1:0] HUE_180  = 9'd180;
   localparam logic [HUE_W-1:0] HUE_240  = 9'd240;
   localparam logic [HUE_W-1:0] HUE_300  = 9'd300;

   localparam logic [HM_W-1:0]  HM_HALF  = 7'd60;
   localparam logic [HM_W-1:0]  HM_FULL  = 7'd120;

   localparam logic [HUE_W-1:0] FULL_SCALE9 = 9'd255;

   // scale factors of the numerators
   localparam logic [NUM_W-1:0] C_MULT   = 23'd120;
   localparam logic [NUM_W-1:0] M_HALF   = 23'd60;
   localparam logic [NUM_W-1:0] DIVISOR  = 23'd30600;

   // reciprocal of 30600, estimate low by at most one
   localparam int RECIP_SHIFT = 24;
   localparam int PROD_W      = NUM_W + 10;
   localparam logic [PROD_W-1:0] RECIP = 33'd548;

   typedef logic [NUM_W-1:0] num_type;
   typedef logic [2:0][NUM_W-1:0] rgb_num_type;
   typedef logic [2:0][FRAC_W-1:0] rgb_byte_type;

   // 60-degree hue sectors
   typedef enum logic [2:0] {
      SECTOR_RED_YELLOW,
      SECTOR_YELLOW_GREEN,
      SECTOR_GREEN_CYAN,
      SECTOR_CYAN_BLUE,
      SECTOR_BLUE_MAGENTA,
      SECTOR_MAGENTA_RED
   } sector_type;

   // load strobes for the two register stages of one module
   typedef struct packed {
      logic load_first;
      logic load_second;
   } pair_load_type;

endpackage
`default_nettype wire

/* design/hsl2rgb_front.sv */
// hue sector, hue triangle and chroma product stages
`default_nettype none
module hsl2rgb_front
   import hsl2rgb_pkg::*;
(
   input  wire logic                clock,
   input  wire pair_load_type       ctrl,
   input  wire logic [HUE_W-1:0]    hue,
   input  wire logic [FRAC_W-1:0]   saturation,
   input  wire logic [FRAC_W-1:0]   lightness,
   output logic [CN_W-1:0]          cn,
   output logic [FRAC_W-1:0]        light,
   output logic [TRI_W-1:0]         tri_val,
   output sector_type               sector
);

   logic [HUE_W-1:0]  hue_wrap;
   logic [HUE_W-1:0]  hue_base;
   logic [HM_W-1:0]   hue_mod;
   sector_type        sector_in;
   logic [TRI_W-1:0]  tri_in;
   logic [HUE_W-1:0]  twol;
   logic [HUE_W-1:0]  light_dist;
   logic [FRAC_W-1:0] a_in;

   logic [FRAC_W-1:0] a_ff;
   logic [FRAC_W-1:0] sat_ff;
   logic [FRAC_W-1:0] light_a_ff;
   logic [TRI_W-1:0]  tri_a_ff;
   sector_type        sector_a_ff;

   logic [CN_W-1:0]   cn_in;
   logic [CN_W-1:0]   cn_ff;
   logic [FRAC_W-1:0] light_b_ff;
   logic [TRI_W-1:0]  tri_b_ff;
   sector_type        sector_b_ff;

   // wrap hue into 0..359
   assign hue_wrap = (hue >= HUE_WRAP) ? hue - HUE_WRAP : hue;

   // sector and start of its 120-degree pair
   always_comb begin
      if (hue_wrap < HUE_60) begin
         sector_in = SECTOR_RED_YELLOW;
         hue_base  = '0;
      end else if (hue_wrap < HUE_120) begin
         sector_in = SECTOR_YELLOW_GREEN;
         hue_base  = '0;
      end else if (hue_wrap < HUE_180) begin
         sector_in = SECTOR_GREEN_CYAN;
         hue_base  = HUE_120;
      end else if (hue_wrap < HUE_240) begin
         sector_in = SECTOR_CYAN_BLUE;
         hue_base  = HUE_120;
      end else if (hue_wrap < HUE_300) begin
         sector_in = SECTOR_BLUE_MAGENTA;
         hue_base  = HUE_240;
      end else begin
         sector_in = SECTOR_MAGENTA_RED;
         hue_base  = HUE_240;
      end
   end

   // triangle 60 - |hm - 60|
   assign hue_mod = HM_W'(hue_wrap - hue_base);
   assign tri_in  = (hue_mod >= HM_HALF) ? TRI_W'(HM_FULL - hue_mod) : hue_mod[TRI_W-1:0];

   // a = 255 - |2l - 255|
   assign twol       = {lightness, 1'b0};
   assign light_dist = (twol >= FULL_SCALE9) ? twol - FULL_SCALE9 : FULL_SCALE9 - twol;
   assign a_in       = FRAC_W'(FULL_SCALE9 - light_dist);

   // first stage
   always_ff @(posedge clock) begin
      if (ctrl.load_first) begin
         a_ff        <= a_in;
         sat_ff      <= saturation;
         light_a_ff  <= lightness;
         tri_a_ff    <= tri_in;
         sector_a_ff <= sector_in;
      end
   end

   // chroma numerator a*s
   assign cn_in = CN_W'(a_ff) * CN_W'(sat_ff);

   // second stage
   always_ff @(posedge clock) begin
      if (ctrl.load_second) begin
         cn_ff       <= cn_in;
         light_b_ff  <= light_a_ff;
         tri_b_ff    <= tri_a_ff;
         sector_b_ff <= sector_a_ff;
      end
   end

   assign cn      = cn_ff;
   assign light   = light_b_ff;
   assign tri_val = tri_b_ff;
   assign sector  = sector_b_ff;

endmodule
`default_nettype wire

/* design/hsl2rgb_mix.sv */
// numerator and channel placement stages
`default_nettype none
module hsl2rgb_mix
   import hsl2rgb_pkg::*;
(
   input  wire logic              clock,
   input  wire pair_load_type     ctrl,
   input  wire logic [CN_W-1:0]   cn,
   input  wire logic [FRAC_W-1:0] light,
   input  wire logic [TRI_W-1:0]  tri_val,
   input  wire sector_type        sector,
   output rgb_num_type            chan_num
);

   num_type     cnum_in;
   num_type     xnum_in;
   num_type     mnum_in;
   num_type     cnum_ff;
   num_type     xnum_ff;
   num_type     mnum_ff;
   sector_type  sector_ff;
   rgb_num_type place;
   rgb_num_type chan_in;
   rgb_num_type chan_ff;

   // numerators of C, X and M
   assign cnum_in = NUM_W'(cn) * C_MULT;
   assign xnum_in = NUM_W'(cn) * NUM_W'({tri_val, 1'b0});
   assign mnum_in = NUM_W'(light) * DIVISOR - NUM_W'(cn) * M_HALF;

   // numerator stage
   always_ff @(posedge clock) begin
      if (ctrl.load_first) begin
         cnum_ff   <= cnum_in;
         xnum_ff   <= xnum_in;
         mnum_ff   <= mnum_in;
         sector_ff <= sector;
      end
   end

   // place C and X by sector, index 0 red, 1 green, 2 blue
   always_comb begin
      case (sector_ff)
         SECTOR_RED_YELLOW: begin
            place[0] = cnum_ff; place[1] = xnum_ff; place[2] = '0;
         end
         SECTOR_YELLOW_GREEN: begin
            place[0] = xnum_ff; place[1] = cnum_ff; place[2] = '0;
         end
         SECTOR_GREEN_CYAN: begin
            place[0] = '0;      place[1] = cnum_ff; place[2] = xnum_ff;
         end
         SECTOR_CYAN_BLUE: begin
            place[0] = '0;      place[1] = xnum_ff; place[2] = cnum_ff;
         end
         SECTOR_BLUE_MAGENTA: begin
            place[0] = xnum_ff; place[1] = '0;      place[2] = cnum_ff;
         end
         default: begin
            place[0] = cnum_ff; place[1] = '0;      place[2] = xnum_ff;
         end
      endcase
   end

   // add offset M to each channel
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         chan_in[i] = place[i] + mnum_ff;
      end
   end

   // channel stage
   always_ff @(posedge clock) begin
      if (ctrl.load_second) begin
         chan_ff <= chan_in;
      end
   end

   assign chan_num = chan_ff;

endmodule
`default_nettype wire

/* design/hsl2rgb_scale.sv */
// divide each channel numerator by 30600, reciprocal estimate then correction
`default_nettype none
module hsl2rgb_scale
   import hsl2rgb_pkg::*;
(
   input  wire logic        clock,
   input  wire pair_load_type ctrl,
   input  wire rgb_num_type chan_num,
   output rgb_byte_type     chan_byte
);

   rgb_byte_type est_in;
   rgb_byte_type est_ff;
   rgb_num_type  num_ff;
   rgb_byte_type byte_in;
   rgb_byte_type byte_ff;

   // quotient estimate from the reciprocal product
   always_comb begin
      logic [PROD_W-1:0] prod;
      for (int i = 0; i < 3; i++) begin
         prod      = PROD_W'(chan_num[i]) * RECIP;
         est_in[i] = prod[RECIP_SHIFT +: FRAC_W];
      end
   end

   // estimate stage
   always_ff @(posedge clock) begin
      if (ctrl.load_first) begin
         est_ff <= est_in;
         num_ff <= chan_num;
      end
   end

   // remainder check lifts a low estimate by one
   always_comb begin
      num_type rem;
      for (int i = 0; i < 3; i++) begin
         rem        = num_ff[i] - NUM_W'(est_ff[i]) * DIVISOR;
         byte_in[i] = est_ff[i] + FRAC_W'(rem >= DIVISOR);
      end
   end

   // output stage
   always_ff @(posedge clock) begin
      if (ctrl.load_second) begin
         byte_ff <= byte_in;
      end
   end

   assign chan_byte = byte_ff;

endmodule
`default_nettype wire

/* design/hsl_to_rgb_converter_unit.sv */
// hsl to rgb converter: six-stage pipeline
// throughput: 1 item per cycle while the output is not stalled; each stage
// holds one item and moves on when the stage after it is free, so empty
// stages fill even while a result waits
// reset: clears the stage valid bits only; data registers are not reset
`default_nettype none
module hsl_to_rgb_converter_unit
   import hsl2rgb_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [HUE_W-1:0]  req_hue,
   input  wire logic [FRAC_W-1:0] req_saturation,
   input  wire logic [FRAC_W-1:0] req_lightness,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic [FRAC_W-1:0]      rsp_red,
   output logic [FRAC_W-1:0]      rsp_green,
   output logic [FRAC_W-1:0]      rsp_blue
);

   localparam int STAGES = 6;

   logic [STAGES-1:0] valid_ff;
   logic [STAGES-1:0] valid_in;
   logic [STAGES-1:0] prev_valid;
   logic [STAGES:0]   stage_ready;
   logic [STAGES-1:0] load;

   pair_load_type     front_ctrl;
   pair_load_type     mix_ctrl;
   pair_load_type     scale_ctrl;

   logic [CN_W-1:0]   cn;
   logic [FRAC_W-1:0] light;
   logic [TRI_W-1:0]  tri_val;
   sector_type        sector;
   rgb_num_type       chan_num;
   rgb_byte_type      chan_byte;

   // stage readiness and valid bit flow
   always_comb begin
      prev_valid = {valid_ff[STAGES-2:0], req_valid};
      stage_ready[STAGES] = rsp_ready;
      for (int k = STAGES - 1; k >= 0; k--) begin
         stage_ready[k] = !valid_ff[k] || stage_ready[k+1];
      end
      for (int k = 0; k < STAGES; k++) begin
         valid_in[k] = stage_ready[k] ? prev_valid[k] : valid_ff[k];
         load[k]     = stage_ready[k] && prev_valid[k];
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign front_ctrl = '{load_first: load[0], load_second: load[1]};
   assign mix_ctrl   = '{load_first: load[2], load_second: load[3]};
   assign scale_ctrl = '{load_first: load[4], load_second: load[5]};

   hsl2rgb_front u_front (
      .clock      (clock),
      .ctrl       (front_ctrl),
      .hue        (req_hue),
      .saturation (req_saturation),
      .lightness  (req_lightness),
      .cn         (cn),
      .light      (light),
      .tri_val    (tri_val),
      .sector     (sector)
   );

   hsl2rgb_mix u_mix (
      .clock    (clock),
      .ctrl     (mix_ctrl),
      .cn       (cn),
      .light    (light),
      .tri_val  (tri_val),
      .sector   (sector),
      .chan_num (chan_num)
   );

   hsl2rgb_scale u_scale (
      .clock     (clock),
      .ctrl      (scale_ctrl),
      .chan_num  (chan_num),
      .chan_byte (chan_byte)
   );

   assign req_ready = stage_ready[0];
   assign rsp_valid = valid_ff[STAGES-1];
   assign rsp_red   = chan_byte[0];
   assign rsp_green = chan_byte[1];
   assign rsp_blue  = chan_byte[2];

endmodule
`default_nettype wire

/* design/hsl2rgb_checker.sv */
// port-level checker for the hsl to rgb converter, bound to the top level
`default_nettype none
`include "hsl_to_rgb_converter_unit_assert.svh"
module hsl2rgb_checker
   import hsl2rgb_pkg::*;
(
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_ready,
   input wire logic [HUE_W-1:0]  req_hue,
   input wire logic [FRAC_W-1:0] req_saturation,
   input wire logic [FRAC_W-1:0] req_lightness,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire logic [FRAC_W-1:0] rsp_red,
   input wire logic [FRAC_W-1:0] rsp_green,
   input wire logic [FRAC_W-1:0] rsp_blue
);

   // a pipeline that is free to drain must take a new item
   `H2R_ASSERT_NOW(a_ready_when_free, (!rsp_valid || rsp_ready), req_ready, "req_ready low while output free")

   // reset empties the pipeline
   `H2R_ASSERT_NEXT(a_reset_empties, reset, !rsp_valid, "result valid right after reset")

   // a stalled result keeps its value
   `H2R_ASSERT_NEXT_RUN(a_rsp_hold, (rsp_valid && !rsp_ready), (rsp_valid && $stable(rsp_red) && $stable(rsp_green) && $stable(rsp_blue)), "stalled result changed")

endmodule

bind hsl_to_rgb_converter_unit hsl2rgb_checker u_checker (.*);
`default_nettype wire
